FILE: sv/obd2_pkg.sv
// types and constants shared by the obd-ii reply decoder
package obd2_pkg;

    // frame acceptance limits
    localparam logic [10:0] RESP_ID_FIRST = 11'h7E8;
    localparam logic [10:0] RESP_ID_LAST  = 11'h7EF;
    localparam logic [3:0]  MIN_LEN       = 4'd4;
    localparam logic [3:0]  MAX_LEN       = 4'd8;
    localparam logic [7:0]  MODE_REPLY    = 8'h41;
    localparam logic [7:0]  PAYLOAD_MASK  = 8'hF0;
    localparam logic [3:0]  MIN_PAYLOAD   = 4'd3;
    localparam logic [3:0]  RPM_PAYLOAD   = 4'd4;

    // supported pids
    localparam logic [7:0] PID_RPM     = 8'h0C;
    localparam logic [7:0] PID_SPEED   = 8'h0D;
    localparam logic [7:0] PID_COOLANT = 8'h05;
    localparam logic [7:0] PID_FUEL    = 8'h2F;
    localparam logic [7:0] PID_MONITOR = 8'h01;

    // parameter codes on the result side
    localparam logic [2:0] CODE_RPM     = 3'd0;
    localparam logic [2:0] CODE_SPEED   = 3'd1;
    localparam logic [2:0] CODE_COOLANT = 3'd2;
    localparam logic [2:0] CODE_FUEL    = 3'd3;
    localparam logic [2:0] CODE_MONITOR = 3'd4;

    // conversion constants
    localparam logic [14:0] COOLANT_OFFSET = 15'd40;
    localparam logic [7:0]  FUEL_SCALE     = 8'd100;
    localparam logic [14:0] FUEL_ROUND     = 15'd127;

    // received frame word, last declared field (can_identifier) in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [7:0]  byte_four;
        logic [7:0]  byte_three;
        logic [7:0]  byte_two;
        logic [7:0]  byte_one;
        logic [7:0]  byte_zero;
        logic [3:0]  data_length;
        logic [10:0] can_identifier;
    } frame_t;

    // decoded result
    typedef struct packed {
        logic               accepted;
        logic [2:0]         parameter_code;
        logic signed [14:0] decoded_value;
    } result_t;

endpackage

FILE: sv/obd2_response_decoder.sv
// top level: input word register, decode logic, result register
// path: an accepted word passes the input register, then the result register, before m_tvalid rises
// throughput: one word per cycle; each register advances when the next one is free or drained
// reset: synchronous active-low aresetn clears both valid flags, no data is reset
// every frame gives exactly one result word; rejected frames give zeros
module obd2_response_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // can_identifier[10:0], data_length[14:11], byte_zero[22:15], byte_one[30:23],
    // byte_two[38:31], byte_three[46:39], byte_four[54:47], zero[55]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // decoded_value[14:0], zero[15]
    output logic [15:0] m_tdata,
    // accepted[0], parameter_code[3:1]
    output logic [3:0]  m_tuser
);
    import obd2_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    frame_t  in_word_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_word_reg;
    result_t decoded;
    logic    out_free;
    logic    advance;

    // handshake between stages
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign in_valid_next  = s_tvalid ? 1'b1 : (in_valid_reg && !out_free);
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= frame_t'(s_tdata);
        end
    end

    obd2_decode u_decode (
        .frame  (in_word_reg),
        .result (decoded)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= decoded;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_word_reg.decoded_value};
    assign m_tuser  = {out_word_reg.parameter_code, out_word_reg.accepted};

`ifndef SYNTH
    // a rejected result carries only zeros
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[3:1] == 3'd0 && m_tdata == 16'd0))
        else $error("rejected result with nonzero payload");

    // accepted results only use defined parameter codes
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] <= CODE_MONITOR))
        else $error("undefined parameter code");

    // both stages full and stalled means no new word is taken
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline stalled and full");

    // no result appears right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

FILE: sv/obd2_decode.sv
// frame check and pid conversion, purely combinational
module obd2_decode (
    input  obd2_pkg::frame_t  frame,
    output obd2_pkg::result_t result
);
    import obd2_pkg::*;

    logic        frame_ok;
    logic [4:0]  payload_end;
    logic [14:0] fuel_num;
    logic [15:0] fuel_sum;
    logic [6:0]  fuel_pct;
    logic        pid_ok;
    logic [2:0]  code;
    logic [14:0] value;

    // header checks: id window, length, payload length, mode
    assign payload_end = {1'b0, frame.byte_zero[3:0]} + 5'd1;
    assign frame_ok = (frame.can_identifier >= RESP_ID_FIRST)
                   && (frame.can_identifier <= RESP_ID_LAST)
                   && (frame.data_length >= MIN_LEN)
                   && (frame.data_length <= MAX_LEN)
                   && ((frame.byte_zero & PAYLOAD_MASK) == 8'd0)
                   && (frame.byte_zero[3:0] >= MIN_PAYLOAD)
                   && (payload_end <= {1'b0, frame.data_length})
                   && (frame.byte_one == MODE_REPLY);

    // fuel: (a*100+127)/255, divide by 255 via x + x>>8 + 1 then shift
    assign fuel_num = 15'(frame.byte_three * FUEL_SCALE) + FUEL_ROUND;
    assign fuel_sum = {1'b0, fuel_num} + 16'(fuel_num >> 8) + 16'd1;
    assign fuel_pct = fuel_sum[14:8];

    // pid conversion
    always_comb begin
        pid_ok = 1'b1;
        code   = CODE_RPM;
        value  = '0;
        unique case (frame.byte_two)
            PID_RPM: begin
                pid_ok = (frame.byte_zero[3:0] >= RPM_PAYLOAD);
                code   = CODE_RPM;
                value  = {1'b0, frame.byte_three, frame.byte_four[7:2]};
            end
            PID_SPEED: begin
                code  = CODE_SPEED;
                value = {7'd0, frame.byte_three};
            end
            PID_COOLANT: begin
                code  = CODE_COOLANT;
                value = {7'd0, frame.byte_three} - COOLANT_OFFSET;
            end
            PID_FUEL: begin
                code  = CODE_FUEL;
                value = {8'd0, fuel_pct};
            end
            PID_MONITOR: begin
                code  = CODE_MONITOR;
                value = {14'd0, frame.byte_three[7]};
            end
            default: begin
                pid_ok = 1'b0;
            end
        endcase
    end

    // rejected frames give all zeros
    always_comb begin
        result.accepted       = frame_ok && pid_ok;
        result.parameter_code = result.accepted ? code : 3'd0;
        result.decoded_value  = result.accepted ? value : 15'sd0;
    end

endmodule

FILE: tb/obd2_reply_checker.sv
// checker for the obd-ii reply decoder: predicts each result word and compares it
module obd2_reply_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int          error_count,
    output int          replies_in_flight
);
    import obd2_pkg::*;

    // decoded results still owed by the block, oldest first
    result_t pending_decodes[$];

    // decode one received frame into the result word the block should give
    function automatic result_t decode_reply(frame_t f);
        result_t r;
        logic    ok;
        int      a;
        int      b;
        r  = '0;
        a  = int'(f.byte_three);
        b  = int'(f.byte_four);
        ok = 1'b0;
        // frame shape, sender and service checks
        if (f.can_identifier >= RESP_ID_FIRST && f.can_identifier <= RESP_ID_LAST &&
            f.data_length >= MIN_LEN && f.data_length <= MAX_LEN &&
            (f.byte_zero & PAYLOAD_MASK) == 8'h00 &&
            int'(f.byte_zero) >= int'(MIN_PAYLOAD) &&
            int'(f.byte_zero) + 1 <= int'(f.data_length) &&
            f.byte_one == MODE_REPLY) begin
            ok = 1'b1;
            case (f.byte_two)
                PID_RPM: begin
                    // byte b must lie inside the payload
                    if (int'(f.byte_zero) < int'(RPM_PAYLOAD)) begin
                        ok = 1'b0;
                    end else begin
                        r.parameter_code = CODE_RPM;
                        r.decoded_value  = 15'((a * 256 + b) / 4);
                    end
                end
                PID_SPEED: begin
                    r.parameter_code = CODE_SPEED;
                    r.decoded_value  = 15'(a);
                end
                PID_COOLANT: begin
                    r.parameter_code = CODE_COOLANT;
                    r.decoded_value  = 15'(a - 40);
                end
                PID_FUEL: begin
                    r.parameter_code = CODE_FUEL;
                    r.decoded_value  = 15'((a * 100 + 127) / 255);
                end
                PID_MONITOR: begin
                    r.parameter_code = CODE_MONITOR;
                    r.decoded_value  = 15'(f.byte_three[7]);
                end
                default: ok = 1'b0;
            endcase
        end
        if (!ok) begin
            r = '0;
        end
        r.accepted = ok;
        return r;
    endfunction

    initial begin
        error_count       = 0;
        replies_in_flight = 0;
    end

    // compare result words first, then queue the prediction for a new frame word
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tuser[3:1], m_tdata[14:0]};
                if (pending_decodes.size() == 0) begin
                    $error("result word with no frame outstanding: %h", got);
                    error_count = error_count + 1;
                end else begin
                    want = pending_decodes.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        error_count = error_count + 1;
                    end
                    if (got.parameter_code !== want.parameter_code) begin
                        $error("parameter_code: expected %0d, got %0d",
                               want.parameter_code, got.parameter_code);
                        error_count = error_count + 1;
                    end
                    if (got.decoded_value !== want.decoded_value) begin
                        $error("decoded_value: expected %0d, got %0d",
                               $signed(want.decoded_value), $signed(got.decoded_value));
                        error_count = error_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_decodes.push_back(decode_reply(frame_t'(s_tdata)));
            end
            replies_in_flight = pending_decodes.size();
        end
    end

endmodule

FILE: tb/obd2_response_decoder_tb.sv
// testbench top for the obd-ii reply decoder: clock, reset, frame stimulus and verdict
module obd2_response_decoder_tb;
    import obd2_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_FRAMES = 130;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    int error_count;
    int replies_in_flight;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles      = 0;

    obd2_response_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    obd2_reply_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .error_count       (error_count),
        .replies_in_flight (replies_in_flight)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic frame_t make_frame(logic [10:0] ident, logic [3:0] len,
                                          logic [7:0] b0, logic [7:0] mode,
                                          logic [7:0] pid, logic [7:0] a, logic [7:0] b);
        frame_t f;
        f.pad            = 1'b0;
        f.can_identifier = ident;
        f.data_length    = len;
        f.byte_zero      = b0;
        f.byte_one       = mode;
        f.byte_two       = pid;
        f.byte_three     = a;
        f.byte_four      = b;
        return f;
    endfunction

    // mostly well-formed replies with random content, the rest broken or pure noise
    function automatic frame_t random_frame();
        frame_t f;
        int     roll;
        f.pad            = 1'b0;
        f.can_identifier = RESP_ID_FIRST + 11'($urandom_range(7));
        f.data_length    = 4'($urandom_range(8, 4));
        f.byte_zero      = 8'($urandom_range(int'(f.data_length) - 1, 3));
        f.byte_one       = MODE_REPLY;
        case ($urandom_range(4))
            0:       f.byte_two = PID_RPM;
            1:       f.byte_two = PID_SPEED;
            2:       f.byte_two = PID_COOLANT;
            3:       f.byte_two = PID_FUEL;
            default: f.byte_two = PID_MONITOR;
        endcase
        f.byte_three = 8'($urandom);
        f.byte_four  = 8'($urandom);
        roll = $urandom_range(99);
        if (roll >= 95) begin
            f.byte_two = 8'($urandom);
        end else if (roll >= 92) begin
            f.byte_one = 8'($urandom);
        end else if (roll >= 88) begin
            f.byte_zero = 8'($urandom);
        end else if (roll >= 85) begin
            f.data_length = 4'($urandom);
        end else if (roll >= 80) begin
            f.can_identifier = 11'($urandom);
        end else if (roll >= 70) begin
            f     = frame_t'(56'({$urandom, $urandom}));
            f.pad = 1'b0;
        end
        return f;
    endfunction

    // offer one frame word, with random idle cycles ahead of it
    task automatic send_frame(frame_t f);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= f;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames: conversions at their extremes
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'd4, MODE_REPLY, PID_RPM, 8'hFF, 8'hFF));
        send_frame(make_frame(RESP_ID_LAST, 4'd5, 8'd4, MODE_REPLY, PID_RPM, 8'h00, 8'h03));
        send_frame(make_frame(RESP_ID_FIRST, 4'd4, 8'd3, MODE_REPLY, PID_SPEED, 8'hFF, 8'h00));
        send_frame(make_frame(11'h7EA, 4'd8, 8'd7, MODE_REPLY, PID_SPEED, 8'h00, 8'hFF));
        send_frame(make_frame(11'h7EB, 4'd4, 8'd3, MODE_REPLY, PID_COOLANT, 8'h00, 8'h00));
        send_frame(make_frame(11'h7EC, 4'd6, 8'd3, MODE_REPLY, PID_COOLANT, 8'hFF, 8'h00));
        send_frame(make_frame(11'h7ED, 4'd4, 8'd3, MODE_REPLY, PID_FUEL, 8'h00, 8'h00));
        send_frame(make_frame(11'h7ED, 4'd4, 8'd3, MODE_REPLY, PID_FUEL, 8'hFF, 8'h00));
        send_frame(make_frame(11'h7EE, 4'd4, 8'd3, MODE_REPLY, PID_FUEL, 8'h01, 8'h00));
        send_frame(make_frame(11'h7EE, 4'd4, 8'd3, MODE_REPLY, PID_FUEL, 8'h02, 8'h00));
        send_frame(make_frame(11'h7E9, 4'd4, 8'd3, MODE_REPLY, PID_MONITOR, 8'h80, 8'h00));
        send_frame(make_frame(11'h7E9, 4'd4, 8'd3, MODE_REPLY, PID_MONITOR, 8'h7F, 8'hFF));
        // engine speed with only three payload bytes
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'd3, MODE_REPLY, PID_RPM, 8'h12, 8'h34));
        // unknown pids
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'd4, MODE_REPLY, 8'h00, 8'h55, 8'hAA));
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'd4, MODE_REPLY, 8'hFF, 8'h55, 8'hAA));
        // identifiers just outside the reply range and at the field ends
        send_frame(make_frame(11'h7E7, 4'd8, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(11'h7F0, 4'd8, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(11'h000, 4'd8, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(11'h7FF, 4'd8, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        // lengths out of range, including above eight
        send_frame(make_frame(RESP_ID_FIRST, 4'd9, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(RESP_ID_FIRST, 4'd15, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(RESP_ID_FIRST, 4'd3, 8'd2, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(RESP_ID_FIRST, 4'd0, 8'd3, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        // bad payload length byte: high nibble, too long, too short
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'h13, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(RESP_ID_FIRST, 4'd4, 8'd4, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'd2, MODE_REPLY, PID_SPEED, 8'h10, 8'h00));
        // wrong service byte
        send_frame(make_frame(RESP_ID_FIRST, 4'd8, 8'd3, 8'h40, PID_SPEED, 8'h10, 8'h00));

        // random frames under each idling mix
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 49;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 49;
                end
                default: begin
                    sender_idle_pct    = 25;
                    receiver_stall_pct = 25;
                end
            endcase
            repeat (RANDOM_FRAMES) send_frame(random_frame());
        end
        s_tvalid <= 1'b0;

        // drain outstanding result words, then allow for the pipeline depth
        do begin
            @(negedge aclk);
        end while (replies_in_flight != 0);
        repeat (8) @(negedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/obd2_pkg.sv
sv/obd2_decode.sv
sv/obd2_response_decoder.sv
tb/obd2_reply_checker.sv
tb/obd2_response_decoder_tb.sv
